### design/gain_scheduled_pd_steering_unit_macros.svh
// Assertion macros for the gain-scheduled PD steering unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GAIN_SCHEDULED_PD_STEERING_UNIT_MACROS_SVH
`define GAIN_SCHEDULED_PD_STEERING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSPD_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSPD_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gspd_pkg.sv
// Package for the gain-scheduled PD steering unit: widths, register indexes,
// reset values and the control types shared with the serial multiplier.
package gspd_pkg;

  localparam int unsigned A_W   = 17;
  localparam int unsigned B_W   = 16;
  localparam int unsigned ACC_W = 34;
  localparam int unsigned CNT_W = $clog2(B_W);

  localparam logic [2:0] CFG_CURVE_THR   = 3'd0;
  localparam logic [2:0] CFG_GAINS_CURVE = 3'd1;
  localparam logic [2:0] CFG_GAINS_STR   = 3'd2;
  localparam logic [2:0] CFG_LIMIT_LEFT  = 3'd3;
  localparam logic [2:0] CFG_LIMIT_RIGHT = 3'd4;
  localparam logic [2:0] CFG_DECAY       = 3'd5;
  localparam logic [2:0] CFG_DIFF_COEFF  = 3'd6;
  localparam logic [2:0] CFG_BASE_SPEEDS = 3'd7;

  localparam logic [14:0]        RST_CURVE_THR   = 15'd2560;
  localparam logic [31:0]        RST_GAINS_CURVE = 32'd4096;
  localparam logic [31:0]        RST_GAINS_STR   = 32'd2048;
  localparam logic signed [15:0] RST_LIMIT_LEFT  = -16'sd7680;
  localparam logic [14:0]        RST_LIMIT_RIGHT = 15'd7680;
  localparam logic [15:0]        RST_DECAY       = 16'd58982;
  localparam logic signed [15:0] RST_DIFF_COEFF  = 16'sd256;
  localparam logic [31:0]        RST_BASE_SPEEDS = 32'd0;

  typedef struct packed {
    logic start;
    logic keep;
    logic b_signed;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

### design/gspd_serial_mul.sv
// Bit-serial shift-and-add multiplier of the steering unit, one multiplier bit per cycle.
// Depends on gspd_pkg for widths and the control and status types.
module gspd_serial_mul import gspd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mul_ctrl_t               ctrl_i,
  input  logic signed [A_W-1:0]   a_i,
  input  logic        [B_W-1:0]   b_i,
  output mul_stat_t               stat_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0] a_q;
  logic        [B_W-1:0]   b_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] partial;
  logic        [CNT_W-1:0] cnt_q;
  logic                    busy_q, done_q, sgn_q, last;

  assign last    = (cnt_q == CNT_W'(B_W - 1));
  assign partial = b_q[0] ? a_q : '0;

  always_comb begin
    if (last && sgn_q) begin
      acc_d = acc_q - partial;
    end else begin
      acc_d = acc_q + partial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q   <= ACC_W'(a_i);
      b_q   <= b_i;
      sgn_q <= ctrl_i.b_signed;
      if (!ctrl_i.keep) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;

endmodule

### design/gain_scheduled_pd_steering_unit.sv
// Gain-scheduled PD steering unit with differential wheel speeds (top level).
// Depends on gspd_pkg, gspd_serial_mul and the assertion macro header.
//
//   channel  direction  handshake                  payload
//   cfg      in         cfg_we_i                   cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o    error_i, sharp_turn_i, line_found_i
//   out      out        out_valid_o / out_ready_i  cmd_angle_o, wheel_l_o, wheel_r_o
//
// An item with a line found runs three products through the bit-serial multiplier (P, D
// and the differential term); one without a line runs two (decay and the differential term).
// A new item is accepted only when the sequencer is idle; a result waiting in the output
// register does not block acceptance, but a finished item waits until that register is free.
// Reset restores the register defaults and clears the stored error and held angle.
module gain_scheduled_pd_steering_unit import gspd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] error_i,
  input  logic               sharp_turn_i,
  input  logic               line_found_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] cmd_angle_o,
  output logic signed [15:0] wheel_l_o,
  output logic signed [15:0] wheel_r_o
);

`include "gain_scheduled_pd_steering_unit_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_PD,
    ST_MUL_DECAY,
    ST_DECAY,
    ST_START_DIFF,
    ST_MUL_DIFF,
    ST_SUM,
    ST_OUT
  } state_e;

  function automatic logic signed [15:0] trunc_sat(input logic signed [32:0] s);
    logic signed [16:0] q;
    begin
      q = s[32:16];
      if (s[32] && (s[15:0] != 16'd0)) begin
        q = q + 17'sd1;
      end
      if (q > 17'sd32767) begin
        trunc_sat = 16'sh7fff;
      end else if (q < -17'sd32768) begin
        trunc_sat = -16'sd32768;
      end else begin
        trunc_sat = q[15:0];
      end
    end
  endfunction

  state_e state_q;

  logic [14:0]        curve_threshold_q;
  logic [31:0]        gains_curve_q, gains_straight_q, base_speeds_q;
  logic signed [15:0] limit_left_q, diff_coeff_q;
  logic [14:0]        limit_right_q;
  logic [15:0]        decay_factor_q;

  logic signed [15:0] err_q, last_error_q, held_q;
  logic               use_curve_q;
  logic signed [32:0] sum_l_q, sum_r_q;
  logic               out_valid_q;
  logic signed [15:0] steer_q, speed_l_q, speed_r_q;

  mul_ctrl_t               mul_ctrl;
  mul_stat_t               mul_stat;
  logic signed [A_W-1:0]   mul_a;
  logic        [B_W-1:0]   mul_b;
  logic signed [ACC_W-1:0] acc;

  logic signed [16:0]      err_ext, err_mag, deriv;
  logic                    use_curve_in;
  logic signed [ACC_W-1:0] pd_sum, dec_sum;
  logic signed [21:0]      pd_rnd, pd_r, lr_ext, ll_ext;
  logic signed [15:0]      pd_angle;
  logic signed [16:0]      dec_rnd;
  logic signed [15:0]      dec_angle;
  logic signed [31:0]      prod;
  logic signed [32:0]      prod_ext, base_l_ext, base_r_ext;

  logic                    chk_wait, chk_snap, chk_left;

  assign err_ext      = {error_i[15], error_i};
  assign err_mag      = err_ext[16] ? -err_ext : err_ext;
  assign use_curve_in = sharp_turn_i || (err_mag > $signed({2'b00, curve_threshold_q}));
  assign deriv        = {err_q[15], err_q} - {last_error_q[15], last_error_q};

  assign pd_sum   = acc + ACC_W'(2048);
  assign pd_rnd   = pd_sum[33:12];
  assign lr_ext   = {7'd0, limit_right_q};
  assign ll_ext   = {{6{limit_left_q[15]}}, limit_left_q};
  assign pd_r     = (pd_rnd > lr_ext) ? lr_ext : pd_rnd;
  assign pd_angle = (pd_r < ll_ext) ? limit_left_q : pd_r[15:0];

  assign dec_sum   = acc + ACC_W'(32768);
  assign dec_rnd   = dec_sum[32:16];
  assign dec_angle = ((dec_rnd > -17'sd256) && (dec_rnd < 17'sd256)) ? 16'sd0 : dec_rnd[15:0];

  assign prod       = acc[31:0];
  assign prod_ext   = {prod[31], prod};
  assign base_l_ext = {base_speeds_q[15], base_speeds_q[15:0], 16'd0};
  assign base_r_ext = {base_speeds_q[31], base_speeds_q[31:16], 16'd0};

  always_comb begin
    mul_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mul_ctrl.start = 1'b1;
          if (line_found_i) begin
            mul_a = err_ext;
            mul_b = use_curve_in ? gains_curve_q[15:0] : gains_straight_q[15:0];
          end else begin
            mul_a = {held_q[15], held_q};
            mul_b = decay_factor_q;
          end
        end
      end
      ST_MUL_P: begin
        if (mul_stat.done) begin
          mul_ctrl.start = 1'b1;
          mul_ctrl.keep  = 1'b1;
          mul_a          = deriv;
          mul_b          = use_curve_q ? gains_curve_q[31:16] : gains_straight_q[31:16];
        end
      end
      ST_START_DIFF: begin
        mul_ctrl.start    = 1'b1;
        mul_ctrl.b_signed = 1'b1;
        mul_a             = {held_q[15], held_q};
        mul_b             = diff_coeff_q;
      end
      default: begin
      end
    endcase
  end

  gspd_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      curve_threshold_q <= RST_CURVE_THR;
      gains_curve_q     <= RST_GAINS_CURVE;
      gains_straight_q  <= RST_GAINS_STR;
      limit_left_q      <= RST_LIMIT_LEFT;
      limit_right_q     <= RST_LIMIT_RIGHT;
      decay_factor_q    <= RST_DECAY;
      diff_coeff_q      <= RST_DIFF_COEFF;
      base_speeds_q     <= RST_BASE_SPEEDS;
      err_q             <= '0;
      last_error_q      <= '0;
      held_q            <= '0;
      use_curve_q       <= 1'b0;
      sum_l_q           <= '0;
      sum_r_q           <= '0;
      out_valid_q       <= 1'b0;
      steer_q           <= '0;
      speed_l_q         <= '0;
      speed_r_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CURVE_THR:   curve_threshold_q <= cfg_data_i[14:0];
          CFG_GAINS_CURVE: gains_curve_q     <= cfg_data_i;
          CFG_GAINS_STR:   gains_straight_q  <= cfg_data_i;
          CFG_LIMIT_LEFT:  limit_left_q      <= cfg_data_i[15:0];
          CFG_LIMIT_RIGHT: limit_right_q     <= cfg_data_i[14:0];
          CFG_DECAY:       decay_factor_q    <= cfg_data_i[15:0];
          CFG_DIFF_COEFF:  diff_coeff_q      <= cfg_data_i[15:0];
          CFG_BASE_SPEEDS: base_speeds_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            err_q       <= error_i;
            use_curve_q <= use_curve_in;
            state_q     <= line_found_i ? ST_MUL_P : ST_MUL_DECAY;
          end
        end
        ST_MUL_P: begin
          if (mul_stat.done) begin
            state_q <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          if (mul_stat.done) begin
            state_q <= ST_PD;
          end
        end
        ST_PD: begin
          held_q       <= pd_angle;
          last_error_q <= err_q;
          state_q      <= ST_START_DIFF;
        end
        ST_MUL_DECAY: begin
          if (mul_stat.done) begin
            state_q <= ST_DECAY;
          end
        end
        ST_DECAY: begin
          held_q  <= dec_angle;
          state_q <= ST_START_DIFF;
        end
        ST_START_DIFF: begin
          state_q <= ST_MUL_DIFF;
        end
        ST_MUL_DIFF: begin
          if (mul_stat.done) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_l_q <= base_l_ext + prod_ext;
          sum_r_q <= base_r_ext - prod_ext;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            steer_q     <= held_q;
            speed_l_q   <= trunc_sat(sum_l_q);
            speed_r_q   <= trunc_sat(sum_r_q);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_angle_o = steer_q;
  assign wheel_l_o   = speed_l_q;
  assign wheel_r_o   = speed_r_q;

  assign chk_wait = (state_q == ST_MUL_P) || (state_q == ST_MUL_D) ||
                    (state_q == ST_MUL_DECAY) || (state_q == ST_MUL_DIFF);
  assign chk_snap = (held_q == 16'sd0) || (held_q >= 16'sd256) || (held_q <= -16'sd256);
  assign chk_left = (held_q >= limit_left_q);

  `GSPD_CHECK_NOW(a_accept_mul_idle, in_valid_i && in_ready_o, !mul_stat.busy, "Busy at accept.")
  `GSPD_CHECK_NOW(a_start_not_busy, mul_ctrl.start, !mul_stat.busy, "Start while busy.")
  `GSPD_CHECK_NOW(a_done_in_wait, mul_stat.done, chk_wait, "Product done outside a wait.")
  `GSPD_CHECK_NEXT(a_decay_snap, state_q == ST_DECAY, chk_snap, "Decayed angle not snapped.")
  `GSPD_CHECK_NEXT(a_left_clamp, state_q == ST_PD && !cfg_we_i, chk_left, "Below left limit.")

endmodule
